// ===== design/ack_paced_keyboard_link_core_macros.svh =====
// assertion shorthands for the keyboard link checker
`ifndef ACK_PACED_KEYBOARD_LINK_CORE_MACROS_SVH
`define ACK_PACED_KEYBOARD_LINK_CORE_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define APKL_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyboard link check failed");

// next-cycle implication, quiet while reset is asserted
`define APKL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyboard link check failed");

`endif

// ===== design/apkl_pkg.sv =====
package apkl_pkg;

	// transmit store depth and index width (index must also hold the depth)
	localparam int TX_DEPTH = 16;
	localparam int IDX_W    = $clog2(TX_DEPTH + 1);
	localparam int INIT_LEN = 16;

	// stream widths
	localparam int IN_W   = 56;
	localparam int OP_W   = 2;
	localparam int OUT_W  = 16;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_READY  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ACK    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEYBOARD_READY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PRESSED    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_RELEASED   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_READY_INTERVAL = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ABORT_TIMEOUT  = 3'd6;

	// request kinds
	localparam logic [OP_W-1:0] OP_POLL      = 2'd0;
	localparam logic [OP_W-1:0] OP_KEY_DOWN  = 2'd1;
	localparam logic [OP_W-1:0] OP_KEY_UP    = 2'd2;
	localparam logic [OP_W-1:0] OP_POWER_OFF = 2'd3;

	// link mode as reported on the result
	localparam logic [1:0] LINK_WAITING = 2'd0;
	localparam logic [1:0] LINK_INIT    = 2'd1;
	localparam logic [1:0] LINK_READY   = 2'd2;

	localparam logic [7:0] PWR_OFF_CMD = 8'hc0;
	localparam logic [7:0] PWR_OFF_ARG = 8'h20;

	typedef enum logic [2:0] {
		MODE_WAITING = 3'b001,
		MODE_INIT    = 3'b010,
		MODE_READY   = 3'b100
	} mode_t;

	function automatic logic [1:0] mode_code(mode_t m);
		logic [1:0] c;
		case (m)
			MODE_WAITING: c = LINK_WAITING;
			MODE_INIT:    c = LINK_INIT;
			MODE_READY:   c = LINK_READY;
			default:      c = LINK_WAITING;
		endcase
		return c;
	endfunction

	// fixed display init sequence
	function automatic logic [7:0] init_byte(logic [3:0] i);
		logic [7:0] b;
		case (i)
			4'd0:    b = 8'he0;
			4'd1:    b = 8'h07;
			4'd2:    b = 8'hcd;
			4'd3:    b = 8'h07;
			4'd4:    b = 8'hc0;
			4'd5:    b = 8'h06;
			4'd6:    b = 8'hc0;
			4'd7:    b = 8'hc5;
			4'd8:    b = 8'hc0;
			4'd9:    b = 8'h04;
			4'd10:   b = 8'hc0;
			4'd11:   b = 8'h03;
			4'd12:   b = 8'hc0;
			4'd13:   b = 8'h02;
			4'd14:   b = 8'hc0;
			4'd15:   b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== design/ack_paced_keyboard_link_core.sv =====
// Keyboard side of a byte link to a display unit. Every request gives exactly one result.
// A poll request may carry one received byte and the current millisecond time; it can
// emit at most one transmit byte. While waiting for the display, the keyboard-ready code is
// sent each time the ready interval has passed; the display-ready code loads the fixed
// sixteen-byte init sequence, and every byte after the first of a loaded buffer goes out
// only on a poll that carries the acknowledge code. A buffer that makes no progress for the
// abort timeout is dropped. Key-down and key-up requests load a two-byte command only when
// keys are accepted; power-off always loads its command. Timing: one request per clock while
// the result stream is not stalled; a request passes the input register, then the result
// register; the link state is updated in the same cycle as the result is registered, so
// back-to-back requests see each other's effect. Configuration writes are applied at once and
// should be made only while no request is in flight.
module ack_paced_keyboard_link_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// request stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// rx_valid[0], rx_byte[8:1], now_ms[40:9], key_code[48:41], zero fill
	input  logic [apkl_pkg::IN_W-1:0]          s_axis_tdata,
	// op[1:0]
	input  logic [apkl_pkg::OP_W-1:0]          s_axis_tuser,
	// result stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// tx_valid[0], tx_byte[8:1], link_mode[10:9], keys_accepted[11],
	// send_complete[12], zero fill
	output logic [apkl_pkg::OUT_W-1:0]         m_axis_tdata,
	// configuration writes
	input  logic                               cfg_wr_en,
	input  logic [apkl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [apkl_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import apkl_pkg::*;

	// configuration registers
	logic [7:0]  code_display_ready_q;
	logic [7:0]  code_display_ack_q;
	logic [7:0]  code_keyboard_ready_q;
	logic [7:0]  code_key_pressed_q;
	logic [7:0]  code_key_released_q;
	logic [15:0] ready_interval_q;
	logic [15:0] abort_timeout_q;

	// input register
	logic             valid_s1;
	logic [OP_W-1:0]  op_s1;
	logic             rx_valid_s1;
	logic [7:0]       rx_byte_s1;
	logic [31:0]      now_s1;
	logic [7:0]       key_s1;

	// result register
	logic             valid_s2;
	logic [OUT_W-1:0] data_s2;

	// link state; the transmit buffer is either the init sequence or two stored bytes
	mode_t            mode_q;
	logic [IDX_W-1:0] len_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] last_idx_q;
	logic [31:0]      last_time_q;
	logic             buf_init_q;
	logic [7:0]       b0_q;
	logic [7:0]       b1_q;

	// next state
	mode_t            nx_mode;
	logic [IDX_W-1:0] nx_len;
	logic [IDX_W-1:0] nx_idx;
	logic [IDX_W-1:0] nx_last_idx;
	logic [31:0]      nx_last_time;
	logic             nx_buf_init;
	logic [7:0]       nx_b0;
	logic [7:0]       nx_b1;

	logic             advance;
	logic             rx_ready;
	logic             ack;
	logic             sent;
	logic [7:0]       sent_byte;
	logic [31:0]      elapsed;
	logic [31:0]      stall_elapsed;
	logic             keys_ok_now;
	logic             nx_all_sent;
	logic             nx_keys_ok;

	// the result register frees itself when taken, so the input side only waits
	// when both stages are full and the result is not being taken
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_display_ready_q  <= 8'd0;
			code_display_ack_q    <= 8'd1;
			code_keyboard_ready_q <= 8'd2;
			code_key_pressed_q    <= 8'd3;
			code_key_released_q   <= 8'd4;
			ready_interval_q      <= 16'd1000;
			abort_timeout_q       <= 16'd300;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DISPLAY_READY:  code_display_ready_q  <= cfg_data[7:0];
				REG_DISPLAY_ACK:    code_display_ack_q    <= cfg_data[7:0];
				REG_KEYBOARD_READY: code_keyboard_ready_q <= cfg_data[7:0];
				REG_KEY_PRESSED:    code_key_pressed_q    <= cfg_data[7:0];
				REG_KEY_RELEASED:   code_key_released_q   <= cfg_data[7:0];
				REG_READY_INTERVAL: ready_interval_q      <= cfg_data;
				REG_ABORT_TIMEOUT:  abort_timeout_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// request handling, all in one pass on the registered request
	always_comb begin
		nx_mode      = mode_q;
		nx_len       = len_q;
		nx_idx       = idx_q;
		nx_last_idx  = last_idx_q;
		nx_last_time = last_time_q;
		nx_buf_init  = buf_init_q;
		nx_b0        = b0_q;
		nx_b1        = b1_q;
		rx_ready     = 1'b0;
		ack          = 1'b0;
		sent         = 1'b0;
		sent_byte    = 8'd0;
		elapsed      = now_s1 - last_time_q;
		stall_elapsed = elapsed;
		keys_ok_now  = (mode_q == MODE_READY) || (idx_q == len_q);

		case (op_s1)
			OP_POLL: begin
				// display-ready wins when both codes match
				rx_ready = rx_valid_s1 && (rx_byte_s1 == code_display_ready_q);
				ack      = rx_valid_s1 && !rx_ready && (rx_byte_s1 == code_display_ack_q);

				if (rx_ready) begin
					nx_mode     = MODE_INIT;
					nx_buf_init = 1'b1;
					nx_idx      = '0;
					nx_len      = IDX_W'(INIT_LEN);
				end else if (ack && mode_q == MODE_INIT && idx_q == len_q) begin
					nx_mode = MODE_READY;
				end

				// periodic ready byte replaces any pending buffer
				if (nx_mode == MODE_WAITING && elapsed >= {16'd0, ready_interval_q}) begin
					nx_b0       = code_keyboard_ready_q;
					nx_buf_init = 1'b0;
					nx_len      = IDX_W'(1);
					nx_idx      = '0;
				end

				// first byte goes unasked, later ones on an ack
				if (nx_len != '0 && nx_idx < nx_len && nx_idx < IDX_W'(TX_DEPTH) &&
					(nx_idx == '0 || ack)) begin
					sent         = 1'b1;
					sent_byte    = nx_buf_init ? init_byte(nx_idx[3:0])
						: (nx_idx[0] ? nx_b1 : nx_b0);
					nx_last_time = now_s1;
					nx_idx       = nx_idx + IDX_W'(1);
					nx_last_idx  = nx_idx;
				end

				// stall check sees the send of this same poll
				if (sent) begin
					stall_elapsed = 32'd0;
				end
				if (nx_idx != nx_len && nx_last_idx == nx_idx &&
					stall_elapsed >= {16'd0, abort_timeout_q}) begin
					nx_len      = '0;
					nx_idx      = '0;
					nx_last_idx = '0;
				end
			end
			OP_KEY_DOWN: begin
				if (keys_ok_now) begin
					nx_b0       = code_key_pressed_q;
					nx_b1       = key_s1;
					nx_buf_init = 1'b0;
					nx_idx      = '0;
					nx_len      = IDX_W'(2);
				end
			end
			OP_KEY_UP: begin
				if (keys_ok_now) begin
					nx_b0       = code_key_released_q;
					nx_b1       = key_s1;
					nx_buf_init = 1'b0;
					nx_idx      = '0;
					nx_len      = IDX_W'(2);
				end
			end
			OP_POWER_OFF: begin
				nx_b0       = PWR_OFF_CMD;
				nx_b1       = PWR_OFF_ARG;
				nx_buf_init = 1'b0;
				nx_idx      = '0;
				nx_len      = IDX_W'(2);
			end
			default: ;
		endcase

		nx_all_sent = (nx_idx == nx_len);
		nx_keys_ok  = (nx_mode == MODE_READY) || nx_all_sent;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			mode_q      <= MODE_WAITING;
			len_q       <= '0;
			idx_q       <= '0;
			last_idx_q  <= '0;
			last_time_q <= 32'd0;
			buf_init_q  <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2    <= 1'b1;
				mode_q      <= nx_mode;
				len_q       <= nx_len;
				idx_q       <= nx_idx;
				last_idx_q  <= nx_last_idx;
				last_time_q <= nx_last_time;
				buf_init_q  <= nx_buf_init;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1       <= s_axis_tuser;
			rx_valid_s1 <= s_axis_tdata[0];
			rx_byte_s1  <= s_axis_tdata[8:1];
			now_s1      <= s_axis_tdata[40:9];
			key_s1      <= s_axis_tdata[48:41];
		end
		if (advance) begin
			b0_q    <= nx_b0;
			b1_q    <= nx_b1;
			data_s2 <= {3'd0, nx_all_sent, nx_keys_ok, mode_code(nx_mode), sent_byte, sent};
		end
	end

endmodule

// ===== design/apkl_checker.sv =====
module apkl_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [apkl_pkg::OUT_W-1:0] m_axis_tdata
);
	import apkl_pkg::*;
	`include "ack_paced_keyboard_link_core_macros.svh"

	// result fields as seen on the port
	logic       stalled;
	logic       res_sent;
	logic [7:0] res_byte;
	logic [1:0] res_mode;
	logic       res_keys;
	logic       res_done;

	assign stalled  = m_axis_tvalid && !m_axis_tready;
	assign res_sent = m_axis_tdata[0];
	assign res_byte = m_axis_tdata[8:1];
	assign res_mode = m_axis_tdata[10:9];
	assign res_keys = m_axis_tdata[11];
	assign res_done = m_axis_tdata[12];

	// a result not taken stays put
	`APKL_ASSERT_NEXT(a_out_hold, stalled, m_axis_tvalid && $stable(m_axis_tdata))

	// no byte sent means the byte field is zero
	`APKL_ASSERT_SAME(a_idle_byte_zero, m_axis_tvalid && !res_sent, res_byte == 8'd0)

	// link mode stays within its three codes
	`APKL_ASSERT_SAME(a_mode_code, m_axis_tvalid, res_mode != 2'd3)

	// keys are accepted exactly when ready or the buffer is fully sent
	`APKL_ASSERT_SAME(a_keys_rule, m_axis_tvalid, res_keys == ((res_mode == LINK_READY) || res_done))

endmodule

bind ack_paced_keyboard_link_core apkl_checker u_apkl_checker (.*);
